[hdl/assert_macros.svh]
// assertion macros used by the console writer rtl (tcw_seq)
// expects clk and rst_n (synchronous, active low) in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/tcw_pkg.sv]
// shared types and constants of the text console writer
// no dependencies
package tcw_pkg;

  // item modes
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // special characters
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;

  localparam logic [2:0] TAB_SPACES  = 3'd4;
  localparam logic [7:0] COLOR_RESET = 8'd15;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_SCROLL,
    ST_CLEAR,
    ST_READ,
    ST_DONE
  } tcw_state_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic [10:0] cursor_position;
    logic [15:0] cell_data;
  } tcw_result_t;

endpackage

[hdl/text_console_writer.sv]
// text console writer: screen store of ROWS x COLUMNS cells and a cursor
// put, tab, newline, read and clear items each post one result; a scroll (when a put
// wraps past the last cell) sweeps the store one cell per cycle through the single
// write port; the next item is taken only after the result is posted
// reset: a clearing pass zeroes the store, in_stall held high meanwhile
// depends on tcw_pkg, tcw_cell_ram, tcw_seq
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: colour register
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_cursor_row,
  output logic [6:0]  out_cursor_column,
  output logic [10:0] out_cursor_position,
  output logic [15:0] out_cell_data
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int AW = $clog2(CELL_COUNT);

  logic [7:0]           text_color_r;
  logic                 out_valid_r;
  tcw_pkg::tcw_result_t out_res_r;

  logic                 res_valid;
  logic                 res_ready;
  tcw_pkg::tcw_result_t res;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [15:0]          mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [15:0]          mem_rdata;

  // colour register, written any time the port strobes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= tcw_pkg::COLOR_RESET;
    end else if (cfg_wr_en) begin
      text_color_r <= cfg_wr_data;
    end
  end

  // output slot: free when empty or its transfer completes this cycle
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload held while stalled
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_row      = out_res_r.cursor_row;
  assign out_cursor_column   = out_res_r.cursor_column;
  assign out_cursor_position = out_res_r.cursor_position;
  assign out_cell_data       = out_res_r.cell_data;

  // cursor and sweep sequencer
  tcw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .text_color    (text_color_r),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  // character/attribute store
  tcw_cell_ram #(
    .DEPTH (CELL_COUNT),
    .WIDTH (16)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[hdl/tcw_cell_ram.sv]
// screen cell store: one write port, one read port with registered data
// no dependencies
module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/tcw_seq.sv]
// sequencer of the console writer: cursor, item decode and screen sweeps
// depends on tcw_pkg and assert_macros.svh; drives tcw_cell_ram
`include "assert_macros.svh"

module tcw_seq #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25,
  localparam int AW = $clog2(ROWS * COLUMNS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_mode,
  input  logic [7:0]          in_char_code,
  input  logic [10:0]         in_cell_index,
  input  logic [7:0]          text_color,
  output logic                res_valid,
  input  logic                res_ready,
  output tcw_pkg::tcw_result_t res,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [15:0]         mem_wdata,
  output logic [AW-1:0]       mem_raddr,
  input  logic [15:0]         mem_rdata
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);
  localparam int KW = $clog2(CELL_COUNT + 1);
  localparam int SW = KW + 1;
  localparam int IW = (KW > 11) ? KW : 11;
  localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);

  tcw_pkg::tcw_state_t state_r, state_nxt;

  logic [7:0]    char_r, char_nxt;
  logic          nl_r, nl_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic          more_r, more_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic          sc_pend_r, sc_pend_nxt;
  logic [AW-1:0] sc_waddr_r, sc_waddr_nxt;
  logic          sc_mem_r, sc_mem_nxt;
  logic [15:0]   res_data_r, res_data_nxt;

  logic          accept;
  logic          cell_ok;
  logic          col_end;
  logic          row_end;
  logic          put_wrap;
  logic          put_done;
  logic          k_last;
  logic          k_end;
  logic [SW-1:0] sc_rd;
  logic          sc_rd_ok;
  logic [15:0]   blank;
  logic [31:0]   row_w;
  logic [31:0]   col_w;
  logic [31:0]   addr_w;

  assign accept   = in_valid && (state_r == tcw_pkg::ST_IDLE);
  assign in_stall = (state_r != tcw_pkg::ST_IDLE);
  assign cell_ok  = IW'(in_cell_index) < IW'(CELL_COUNT);
  assign col_end  = (col_r == CW'(COLUMNS - 1));
  assign row_end  = (row_r == RW'(ROWS - 1));
  assign put_wrap = col_end && row_end;
  // newline stops when the column comes back to zero
  assign put_done = nl_r ? col_end : (cnt_r == 3'd1);
  assign k_last   = (k_r == KW'(CELL_COUNT - 1));
  assign k_end    = (k_r == KW'(CELL_COUNT));
  assign sc_rd    = SW'(k_r) + SW'(COLUMNS);
  assign sc_rd_ok = sc_rd < SW'(CELL_COUNT);
  assign blank    = {text_color, tcw_pkg::CHAR_SPACE};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tcw_pkg::ST_INIT;
      row_r     <= '0;
      col_r     <= '0;
      addr_r    <= '0;
      k_r       <= '0;
      sc_pend_r <= 1'b0;
      more_r    <= 1'b0;
      cnt_r     <= '0;
      nl_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      addr_r    <= addr_nxt;
      k_r       <= k_nxt;
      sc_pend_r <= sc_pend_nxt;
      more_r    <= more_nxt;
      cnt_r     <= cnt_nxt;
      nl_r      <= nl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    sc_waddr_r <= sc_waddr_nxt;
    sc_mem_r   <= sc_mem_nxt;
    res_data_r <= res_data_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcw_pkg::ST_INIT: begin
        if (k_last) state_nxt = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            tcw_pkg::MODE_PUT:   state_nxt = tcw_pkg::ST_PUT;
            tcw_pkg::MODE_READ:  state_nxt = cell_ok ? tcw_pkg::ST_READ : tcw_pkg::ST_DONE;
            tcw_pkg::MODE_CLEAR: state_nxt = tcw_pkg::ST_CLEAR;
            default:             state_nxt = tcw_pkg::ST_DONE;
          endcase
        end
      end
      tcw_pkg::ST_PUT: begin
        if (put_wrap) state_nxt = tcw_pkg::ST_SCROLL;
        else if (put_done) state_nxt = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_SCROLL: begin
        if (k_end) state_nxt = more_r ? tcw_pkg::ST_PUT : tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_CLEAR: begin
        if (k_last) state_nxt = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_READ: begin
        state_nxt = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_DONE: begin
        if (res_ready) state_nxt = tcw_pkg::ST_IDLE;
      end
      default: state_nxt = tcw_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    char_nxt     = char_r;
    nl_nxt       = nl_r;
    cnt_nxt      = cnt_r;
    more_nxt     = more_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    addr_nxt     = addr_r;
    k_nxt        = k_r;
    sc_pend_nxt  = sc_pend_r;
    sc_waddr_nxt = sc_waddr_r;
    sc_mem_nxt   = sc_mem_r;
    res_data_nxt = res_data_r;
    mem_we       = 1'b0;
    mem_waddr    = addr_r;
    mem_wdata    = 16'd0;
    mem_raddr    = cell_ok ? AW'(in_cell_index) : '0;
    res_valid    = 1'b0;
    case (state_r)
      tcw_pkg::ST_INIT: begin
        // clearing pass after reset
        mem_we    = 1'b1;
        mem_waddr = k_r[AW-1:0];
        mem_wdata = 16'd0;
        k_nxt     = k_last ? '0 : k_r + KW'(1);
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          res_data_nxt = 16'd0;
          k_nxt        = '0;
          sc_pend_nxt  = 1'b0;
          nl_nxt       = (in_char_code == tcw_pkg::CHAR_NEWLINE);
          cnt_nxt      = (in_char_code == tcw_pkg::CHAR_TAB) ? tcw_pkg::TAB_SPACES : 3'd1;
          if (in_char_code == tcw_pkg::CHAR_NEWLINE || in_char_code == tcw_pkg::CHAR_TAB) begin
            char_nxt = tcw_pkg::CHAR_SPACE;
          end else begin
            char_nxt = in_char_code;
          end
        end
      end
      tcw_pkg::ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = {text_color, char_r};
        cnt_nxt   = cnt_r - 3'd1;
        if (put_wrap) begin
          // cursor lands on the start of the bottom row after the scroll
          col_nxt     = '0;
          addr_nxt    = LAST_ROW_BASE;
          more_nxt    = !put_done;
          k_nxt       = '0;
          sc_pend_nxt = 1'b0;
        end else if (col_end) begin
          col_nxt  = '0;
          row_nxt  = row_r + RW'(1);
          addr_nxt = addr_r + AW'(1);
        end else begin
          col_nxt  = col_r + CW'(1);
          addr_nxt = addr_r + AW'(1);
        end
      end
      tcw_pkg::ST_SCROLL: begin
        // read one row ahead, write the cell behind in the next cycle
        mem_raddr    = sc_rd_ok ? sc_rd[AW-1:0] : '0;
        sc_pend_nxt  = !k_end;
        sc_waddr_nxt = k_r[AW-1:0];
        sc_mem_nxt   = sc_rd_ok;
        mem_we       = sc_pend_r;
        mem_waddr    = sc_waddr_r;
        mem_wdata    = sc_mem_r ? {text_color, mem_rdata[7:0]} : blank;
        k_nxt        = k_end ? '0 : k_r + KW'(1);
      end
      tcw_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[AW-1:0];
        mem_wdata = blank;
        k_nxt     = k_last ? '0 : k_r + KW'(1);
        if (k_last) begin
          row_nxt  = '0;
          col_nxt  = '0;
          addr_nxt = '0;
        end
      end
      tcw_pkg::ST_READ: begin
        res_data_nxt = mem_rdata;
      end
      tcw_pkg::ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  assign row_w  = 32'(row_r);
  assign col_w  = 32'(col_r);
  assign addr_w = 32'(addr_r);

  always_comb begin
    res.cursor_row      = row_w[4:0];
    res.cursor_column   = col_w[6:0];
    res.cursor_position = addr_w[10:0];
    res.cell_data       = res_data_r;
  end

  `CHK_IMPLY(a_addr_track, state_r == tcw_pkg::ST_IDLE, int'(addr_r) == int'(row_r) * COLUMNS + int'(col_r), "linear cursor out of step with row and column")
  `CHK_IMPLY(a_wr_range, mem_we, int'(mem_waddr) < CELL_COUNT, "screen write beyond the store")
  `CHK_IMPLY(a_scroll_exit, state_r == tcw_pkg::ST_SCROLL && state_nxt != tcw_pkg::ST_SCROLL, col_r == '0 && row_end, "scroll left the cursor off the bottom row start")
  `CHK_NEXT(a_done_hold, state_r == tcw_pkg::ST_DONE && !res_ready, state_r == tcw_pkg::ST_DONE, "result dropped while output slot full")

endmodule
